/* hw/rtl/ewap_pkg.sv */
package ewap_pkg;

    // Fixed field widths
    localparam int NUM_SAMPLES = 8;
    localparam int POWER_W     = 31;
    localparam int POWER_FRAC  = 30;
    localparam int STEP_W      = 8;
    localparam int CHAN_W      = 4;
    localparam int MASK_W      = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8;

    // Smoothing factor 0.095 in Q0.16, kept signed for the delta product
    localparam int                   SMOOTH_W     = 13;
    localparam logic signed [SMOOTH_W:0] SMOOTH_Q16 = 14'sd6226;
    localparam int                   SMOOTH_SHIFT = 16;
    localparam int                   ROUND_HALF   = 32768;

    localparam logic [POWER_W-1:0] POWER_FULL = 31'h4000_0000;

    // Quotient bits resolved per divider cycle
    localparam int DIV_BITS = 8;

    // Reset values of the configuration registers
    localparam logic             ENABLED_RST   = 1'b0;
    localparam logic             FORMAT_OK_RST = 1'b1;
    localparam logic [STEP_W-1:0] STEP_RST     = 8'd48;
    localparam logic [CHAN_W-1:0] CHAN_RST     = 4'd2;
    localparam logic [MASK_W-1:0] MASK_RST     = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLED         = 3'd0,
        CFG_FORMAT_OK       = 3'd1,
        CFG_DECIMATION_STEP = 3'd2,
        CFG_CHANNEL_COUNT   = 3'd3,
        CFG_CHANNEL_MASK    = 3'd4
    } cfg_index_t;

    // Effective configuration, already clamped
    typedef struct packed {
        logic              active;
        logic [STEP_W-1:0] step;
        logic [CHAN_W-1:0] chan_n;
        logic [MASK_W-1:0] mask;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic sq_step;
        logic div_step;
        logic scale;
        logic update;
        logic out_load;
        logic counted;
    } cmd_t;

    typedef struct packed {
        logic loaded;
    } status_t;

endpackage

/* hw/rtl/ewap_frame_if.sv */
interface ewap_frame_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic                          buffer_start;
    logic signed [SAMPLE_BITS-1:0] sample_0;
    logic signed [SAMPLE_BITS-1:0] sample_1;
    logic signed [SAMPLE_BITS-1:0] sample_2;
    logic signed [SAMPLE_BITS-1:0] sample_3;
    logic signed [SAMPLE_BITS-1:0] sample_4;
    logic signed [SAMPLE_BITS-1:0] sample_5;
    logic signed [SAMPLE_BITS-1:0] sample_6;
    logic signed [SAMPLE_BITS-1:0] sample_7;

    modport source (
        output valid, buffer_start,
        output sample_0, sample_1, sample_2, sample_3,
        output sample_4, sample_5, sample_6, sample_7,
        input  ready
    );

    modport sink (
        input  valid, buffer_start,
        input  sample_0, sample_1, sample_2, sample_3,
        input  sample_4, sample_5, sample_6, sample_7,
        output ready
    );
endinterface

/* hw/rtl/ewap_power_if.sv */
interface ewap_power_if;
    logic                           valid;
    logic                           ready;
    logic [ewap_pkg::POWER_W-1:0]   power_level;
    logic                           power_valid;
    logic                           frame_counted;

    modport source (
        output valid, power_level, power_valid, frame_counted,
        input  ready
    );

    modport sink (
        input  valid, power_level, power_valid, frame_counted,
        output ready
    );
endinterface

/* hw/rtl/ewap_cfg.sv */
module ewap_cfg #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ewap_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ewap_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output ewap_pkg::cfg_t                   cfg
);

    logic                          enabled_reg;
    logic                          format_ok_reg;
    logic [ewap_pkg::STEP_W-1:0]   step_reg;
    logic [ewap_pkg::CHAN_W-1:0]   chan_reg;
    logic [ewap_pkg::MASK_W-1:0]   mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= ewap_pkg::ENABLED_RST;
            format_ok_reg <= ewap_pkg::FORMAT_OK_RST;
            step_reg      <= ewap_pkg::STEP_RST;
            chan_reg      <= ewap_pkg::CHAN_RST;
            mask_reg      <= ewap_pkg::MASK_RST;
        end
        else if (cfg_we)
        begin
            unique case (ewap_pkg::cfg_index_t'(cfg_index))
                ewap_pkg::CFG_ENABLED:         enabled_reg   <= cfg_wdata[0];
                ewap_pkg::CFG_FORMAT_OK:       format_ok_reg <= cfg_wdata[0];
                ewap_pkg::CFG_DECIMATION_STEP: step_reg      <= cfg_wdata[ewap_pkg::STEP_W-1:0];
                ewap_pkg::CFG_CHANNEL_COUNT:   chan_reg      <= cfg_wdata[ewap_pkg::CHAN_W-1:0];
                ewap_pkg::CFG_CHANNEL_MASK:    mask_reg      <= cfg_wdata[ewap_pkg::MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // Zero step counts every frame; channel count clamps to 1..MAX_CHANNELS
    always_comb
    begin
        cfg.active = enabled_reg & format_ok_reg;
        cfg.step   = (step_reg == '0) ? ewap_pkg::STEP_W'(1) : step_reg;
        if (chan_reg == '0)
            cfg.chan_n = ewap_pkg::CHAN_W'(1);
        else if (chan_reg > ewap_pkg::CHAN_W'(MAX_CHANNELS))
            cfg.chan_n = ewap_pkg::CHAN_W'(MAX_CHANNELS);
        else
            cfg.chan_n = chan_reg;
        cfg.mask = mask_reg;
    end

endmodule

/* hw/rtl/ewap_ctrl.sv */
module ewap_ctrl #(
    parameter int MAX_CHANNELS = 8,
    parameter int DIV_STEPS    = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ewap_pkg::cfg_t      cfg,
    input  logic                in_valid,
    input  logic                buffer_start,
    output logic                in_ready,
    input  logic                out_ready,
    output logic                out_valid,
    input  ewap_pkg::status_t   status,
    output ewap_pkg::cmd_t      cmd
);

    localparam int CNT_MAX = (MAX_CHANNELS > DIV_STEPS) ? MAX_CHANNELS : DIV_STEPS;
    localparam int CNT_W   = (CNT_MAX > 1) ? $clog2(CNT_MAX) : 1;

    typedef enum logic [2:0] {
        IDLE,
        SQUARE,
        DIVIDE,
        SCALE,
        UPDATE,
        DONE
    } state_t;

    state_t                      state_reg, state_next;
    logic [ewap_pkg::STEP_W-1:0] phase_reg, phase_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        counted_reg, counted_next;
    logic                        out_valid_reg, out_valid_next;

    logic                        in_fire;
    logic [ewap_pkg::STEP_W-1:0] ph_start;
    logic [ewap_pkg::STEP_W:0]   ph_inc;

    assign in_ready  = (state_reg == IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    assign ph_start = buffer_start ? '0 : phase_reg;
    assign ph_inc   = {1'b0, ph_start} + 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        counted_next   = counted_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.counted    = counted_reg;

        if (out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            IDLE:
            begin
                if (in_fire)
                begin
                    cmd.capture = 1'b1;
                    if (cfg.active)
                    begin
                        // Wrap phase at the step, also when the step shrank below it
                        phase_next = (ph_inc >= {1'b0, cfg.step}) ? '0
                                                                  : ph_inc[ewap_pkg::STEP_W-1:0];
                        counted_next = (ph_start == '0);
                        cnt_next     = CNT_W'(cfg.chan_n - 1'b1);
                        state_next   = (ph_start == '0) ? SQUARE : DONE;
                    end
                    else
                    begin
                        counted_next = 1'b0;
                        state_next   = DONE;
                    end
                end
            end
            SQUARE:
            begin
                cmd.sq_step = 1'b1;
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    cnt_next   = CNT_W'(DIV_STEPS - 1);
                    state_next = DIVIDE;
                end
            end
            DIVIDE:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = SCALE;
            end
            SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = status.loaded ? UPDATE : DONE;
            end
            UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = DONE;
            end
            DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            phase_reg     <= '0;
            cnt_reg       <= '0;
            counted_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            counted_reg   <= counted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_fire_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg != IDLE)
        else $error("accepted frame did not start processing");

    a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result overwrote an untaken result");

    a_square_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == SQUARE |-> cnt_reg < cfg.chan_n)
        else $error("channel counter beyond channel count");

    a_gated_not_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !cfg.active) |=> (state_reg == DONE && !counted_reg))
        else $error("gated frame entered the datapath");

endmodule

/* hw/rtl/ewap_dp.sv */
module ewap_dp #(
    parameter int MAX_CHANNELS = 8,
    parameter int SAMPLE_BITS  = 16,
    parameter int DIV_STEPS    = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ewap_pkg::cfg_t                cfg,
    input  logic [SAMPLE_BITS-1:0]        samples [ewap_pkg::NUM_SAMPLES],
    input  ewap_pkg::cmd_t                cmd,
    output ewap_pkg::status_t             status,
    output logic [ewap_pkg::POWER_W-1:0]  power_level,
    output logic                          power_valid,
    output logic                          frame_counted
);

    localparam int SQ_W   = 2 * SAMPLE_BITS - 1;
    localparam int DIV_W  = DIV_STEPS * ewap_pkg::DIV_BITS;
    localparam int FRAC   = 2 * (SAMPLE_BITS - 1);
    localparam int DOWN   = (FRAC > ewap_pkg::POWER_FRAC) ? FRAC - ewap_pkg::POWER_FRAC : 0;
    localparam int UP     = (FRAC < ewap_pkg::POWER_FRAC) ? ewap_pkg::POWER_FRAC - FRAC : 0;
    localparam int EXT_W  = SQ_W + UP;
    localparam int DELTA_W = ewap_pkg::POWER_W + 1;
    localparam int PROD_W  = DELTA_W + ewap_pkg::SMOOTH_W + 1;

    logic [SAMPLE_BITS-1:0]        sample_reg [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0]       mask_reg;
    logic [DIV_W-1:0]              sum_reg, sum_next;
    logic [ewap_pkg::CHAN_W-1:0]   rem_reg, rem_next;
    logic signed [PROD_W-1:0]      prod_reg;
    logic [ewap_pkg::POWER_W-1:0]  power_reg, power_next;
    logic                          loaded_reg;
    logic [ewap_pkg::POWER_W-1:0]  out_power_reg;
    logic                          out_loaded_reg;
    logic                          out_counted_reg;

    logic [SAMPLE_BITS-1:0]        mag;
    logic [2*SAMPLE_BITS-1:0]      sq_full;
    logic [SQ_W-1:0]               quot_lo;
    logic [EXT_W-1:0]              mean_ext;
    logic [ewap_pkg::POWER_W-1:0]  mean;
    logic signed [DELTA_W-1:0]     delta;
    logic signed [PROD_W-1:0]      prod_next;
    logic signed [PROD_W-1:0]      rounded;
    logic signed [PROD_W-1:0]      adjust;
    logic signed [PROD_W-1:0]      power_ext;
    logic signed [PROD_W-1:0]      power_sum;
    logic [DIV_W-1:0]              div_bits;
    logic [ewap_pkg::CHAN_W-1:0]   div_rem;

    // Square of the head channel; magnitude of the most negative code fits unsigned
    assign mag     = sample_reg[0][SAMPLE_BITS-1] ? (~sample_reg[0] + 1'b1) : sample_reg[0];
    assign sq_full = mag * mag;

    // Restoring division by the channel count, several quotient bits a cycle
    always_comb
    begin
        logic [ewap_pkg::CHAN_W-1:0] trial;
        logic                        qbit;
        div_bits = sum_reg;
        div_rem  = rem_reg;
        for (int i = 0; i < ewap_pkg::DIV_BITS; i++)
        begin
            trial    = {div_rem[ewap_pkg::CHAN_W-2:0], div_bits[DIV_W-1]};
            qbit     = (trial >= cfg.chan_n);
            div_rem  = qbit ? (trial - cfg.chan_n) : trial;
            div_bits = {div_bits[DIV_W-2:0], qbit};
        end
    end

    always_comb
    begin
        sum_next = sum_reg;
        rem_next = rem_reg;
        if (cmd.capture)
        begin
            sum_next = '0;
            rem_next = '0;
        end
        else if (cmd.sq_step)
        begin
            if (mask_reg[0])
                sum_next = sum_reg + DIV_W'(sq_full[SQ_W-1:0]);
        end
        else if (cmd.div_step)
        begin
            sum_next = div_bits;
            rem_next = div_rem;
        end
    end

    // Quotient rescaled to Q1.30
    assign quot_lo  = sum_reg[SQ_W-1:0];
    assign mean_ext = EXT_W'(quot_lo >> DOWN) << UP;
    assign mean     = ewap_pkg::POWER_W'(mean_ext);

    // p + ((A*(x-p) + half) >>> 16) equals the rounded convex blend
    assign delta     = $signed({1'b0, mean}) - $signed({1'b0, power_reg});
    assign prod_next = delta * ewap_pkg::SMOOTH_Q16;
    assign rounded   = prod_reg + PROD_W'(ewap_pkg::ROUND_HALF);
    assign adjust    = rounded >>> ewap_pkg::SMOOTH_SHIFT;
    assign power_ext = $signed({{(PROD_W - ewap_pkg::POWER_W){1'b0}}, power_reg});
    assign power_sum = power_ext + adjust;

    always_comb
    begin
        power_next = power_reg;
        if (cmd.scale && !loaded_reg)
            power_next = mean;
        else if (cmd.update)
            power_next = power_sum[ewap_pkg::POWER_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
                sample_reg[i] <= samples[i];
            mask_reg <= cfg.mask[MAX_CHANNELS-1:0];
        end
        else if (cmd.sq_step)
        begin
            // Advance the next channel to the head
            for (int i = 0; i < MAX_CHANNELS - 1; i++)
                sample_reg[i] <= sample_reg[i+1];
            mask_reg <= mask_reg >> 1;
        end
        sum_reg <= sum_next;
        rem_reg <= rem_next;
        if (cmd.scale)
            prod_reg <= prod_next;
        if (cmd.out_load)
        begin
            out_power_reg   <= power_reg;
            out_loaded_reg  <= loaded_reg;
            out_counted_reg <= cmd.counted;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_reg  <= '0;
            loaded_reg <= 1'b0;
        end
        else
        begin
            power_reg <= power_next;
            if (cmd.scale)
                loaded_reg <= 1'b1;
        end
    end

    assign status.loaded = loaded_reg;
    assign power_level   = out_power_reg;
    assign power_valid   = out_loaded_reg;
    assign frame_counted = out_counted_reg;

    a_power_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
        power_reg <= ewap_pkg::POWER_FULL)
        else $error("power above full scale");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |=> rem_reg < cfg.chan_n)
        else $error("divider remainder not below channel count");

endmodule

/* hw/rtl/ewma_audio_power_tracker.sv */
// Smoothed mean-square power meter for interleaved audio frames of up to
// MAX_CHANNELS signed Q1.(SAMPLE_BITS-1) samples. One frame is taken per input
// transaction and exactly one result transaction follows it, carrying the held
// Q1.30 power, whether a first value has been loaded, and whether this frame
// updated it. A gated or skipped frame goes from acceptance straight to its
// result. A counted frame runs one squarer over the channels, one per cycle,
// then a divider by the channel count that resolves 8 quotient bits a cycle,
// then the smoothing multiply and the update; the frame that loads the first
// value skips the update. The next frame is taken once the previous result
// sits in the output register.
module ewma_audio_power_tracker #(
    parameter int MAX_CHANNELS = 8,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ewap_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ewap_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    ewap_frame_if.sink                       frame,
    ewap_power_if.source                     power
);

    localparam int SUM_W     = 2 * SAMPLE_BITS - 1 + $clog2(MAX_CHANNELS);
    localparam int DIV_STEPS = (SUM_W + ewap_pkg::DIV_BITS - 1) / ewap_pkg::DIV_BITS;

    ewap_pkg::cfg_t         cfg;
    ewap_pkg::cmd_t         cmd;
    ewap_pkg::status_t      status;
    logic                   in_ready;
    logic                   out_valid;
    logic [SAMPLE_BITS-1:0] frame_samples [ewap_pkg::NUM_SAMPLES];

    assign frame_samples[0] = frame.sample_0;
    assign frame_samples[1] = frame.sample_1;
    assign frame_samples[2] = frame.sample_2;
    assign frame_samples[3] = frame.sample_3;
    assign frame_samples[4] = frame.sample_4;
    assign frame_samples[5] = frame.sample_5;
    assign frame_samples[6] = frame.sample_6;
    assign frame_samples[7] = frame.sample_7;

    assign frame.ready = in_ready;
    assign power.valid = out_valid;

    ewap_cfg #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ewap_ctrl #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .DIV_STEPS    (DIV_STEPS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (frame.valid),
        .buffer_start (frame.buffer_start),
        .in_ready     (in_ready),
        .out_ready    (power.ready),
        .out_valid    (out_valid),
        .status       (status),
        .cmd          (cmd)
    );

    ewap_dp #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .DIV_STEPS    (DIV_STEPS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .samples       (frame_samples),
        .cmd           (cmd),
        .status        (status),
        .power_level   (power.power_level),
        .power_valid   (power.power_valid),
        .frame_counted (power.frame_counted)
    );

endmodule

/* tb/ewma_audio_power_tracker_tb.sv */
`timescale 1ns / 100ps

module ewma_audio_power_tracker_tb;

    localparam int SMP_W          = 16;
    localparam int NUM_PHASES     = 14;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int GATED_ITEMS    = 30;
    localparam int LONG_HOLD      = 200;
    localparam int CYCLE_LIMIT    = 300000;

    localparam longint unsigned ALPHA_Q16 = 6226;
    localparam longint unsigned ONE_Q16   = 65536;

    typedef struct packed {
        logic                                       buf_start;
        logic [ewap_pkg::NUM_SAMPLES-1:0][SMP_W-1:0] smp;
    } frame_t;

    typedef struct packed {
        logic [ewap_pkg::POWER_W-1:0] level;
        logic                         loaded;
        logic                         counted;
    } power_rec_t;

    typedef struct {
        bit                   is_cfg;
        ewap_pkg::cfg_index_t idx;
        logic [7:0]           wdata;
        frame_t               frm;
        bit                   typed;
        power_rec_t           want;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic                            cfg_we;
    logic [ewap_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ewap_pkg::CFG_DATA_W-1:0] cfg_wdata;

    ewap_frame_if #(.SAMPLE_BITS(SMP_W)) frame_if ();
    ewap_power_if power_if ();

    ewma_audio_power_tracker DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .frame     (frame_if),
        .power     (power_if)
    );

    // register shadow and tracker state
    logic        cfg_en;
    logic        cfg_fmt;
    logic [7:0]  cfg_step;
    logic [3:0]  cfg_chans;
    logic [7:0]  cfg_mask;
    logic [7:0]  phase_pos;
    logic [31:0] pwr_acc;
    logic        pwr_loaded;

    power_rec_t pending[$];
    dir_row_t   dir_rows[$];
    power_rec_t got;
    power_rec_t exp_rec;

    bit idle_on;
    bit hold_request;
    int errors       = 0;
    int frames_sent;
    int results_seen = 0;
    int counted_seen = 0;
    int cycle_cnt    = 0;

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
                     pending.size());
            $display("Verification failed");
            $finish;
        end
    end

    function automatic power_rec_t track_frame(frame_t f);
        power_rec_t      r;
        int unsigned     ph;
        int unsigned     stride;
        int unsigned     chans;
        longint          sv;
        longint unsigned sq_sum;
        longint unsigned mean;
        longint unsigned mix;
        r.counted = 1'b0;
        if (cfg_en && cfg_fmt)
        begin
            stride = (cfg_step == 0) ? 1 : cfg_step;
            ph = f.buf_start ? 0 : phase_pos;
            if (ph == 0)
            begin
                // zero count acts as one, counts above the lane total saturate
                chans = (cfg_chans == 0) ? 1 :
                        (cfg_chans > ewap_pkg::NUM_SAMPLES) ? ewap_pkg::NUM_SAMPLES :
                                                              cfg_chans;
                sq_sum = 0;
                for (int c = 0; c < chans; c++)
                begin
                    if (cfg_mask[c])
                    begin
                        sv = longint'($signed(f.smp[c]));
                        sq_sum += sv * sv;
                    end
                end
                mean = sq_sum / chans;
                if (!pwr_loaded)
                begin
                    pwr_acc = mean[31:0];
                    pwr_loaded = 1'b1;
                end
                else
                begin
                    mix = ALPHA_Q16 * mean + (ONE_Q16 - ALPHA_Q16) * pwr_acc + ONE_Q16 / 2;
                    pwr_acc = mix[47:16];
                end
                r.counted = 1'b1;
            end
            ph = ph + 1;
            phase_pos = (ph >= stride) ? 8'd0 : 8'(ph);
        end
        r.level = pwr_acc[ewap_pkg::POWER_W-1:0];
        r.loaded = pwr_loaded;
        return r;
    endfunction

    function automatic logic [SMP_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4: return 16'($urandom_range(0, 511) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void add_cfg(ewap_pkg::cfg_index_t idx, logic [7:0] data);
        dir_row_t r;
        r = '{idx: ewap_pkg::CFG_ENABLED, default: '0};
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.wdata = data;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_frame(logic bs,
                                      logic [ewap_pkg::NUM_SAMPLES-1:0][SMP_W-1:0] smp);
        dir_row_t r;
        r = '{idx: ewap_pkg::CFG_ENABLED, default: '0};
        r.frm.buf_start = bs;
        r.frm.smp = smp;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_known(logic bs,
                                      logic [ewap_pkg::NUM_SAMPLES-1:0][SMP_W-1:0] smp,
                                      logic [ewap_pkg::POWER_W-1:0] lvl, logic ld,
                                      logic cnt);
        dir_row_t r;
        r = '{idx: ewap_pkg::CFG_ENABLED, default: '0};
        r.frm.buf_start = bs;
        r.frm.smp = smp;
        r.typed = 1'b1;
        r.want.level = lvl;
        r.want.loaded = ld;
        r.want.counted = cnt;
        dir_rows.push_back(r);
    endfunction

    task automatic write_reg(input ewap_pkg::cfg_index_t idx, input logic [7:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            ewap_pkg::CFG_ENABLED:         cfg_en = data[0];
            ewap_pkg::CFG_FORMAT_OK:       cfg_fmt = data[0];
            ewap_pkg::CFG_DECIMATION_STEP: cfg_step = data;
            ewap_pkg::CFG_CHANNEL_COUNT:   cfg_chans = data[3:0];
            ewap_pkg::CFG_CHANNEL_MASK:    cfg_mask = data;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // hold the input, wait for every outstanding result, then let the pipe settle
    task automatic drain_results(input int tail);
        frame_if.valid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    task automatic send_frame(input frame_t f, input bit typed, input power_rec_t typed_rec);
        power_rec_t want;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            frame_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        frame_if.valid        <= 1'b1;
        frame_if.buffer_start <= f.buf_start;
        frame_if.sample_0     <= f.smp[0];
        frame_if.sample_1     <= f.smp[1];
        frame_if.sample_2     <= f.smp[2];
        frame_if.sample_3     <= f.smp[3];
        frame_if.sample_4     <= f.smp[4];
        frame_if.sample_5     <= f.smp[5];
        frame_if.sample_6     <= f.smp[6];
        frame_if.sample_7     <= f.smp[7];
        @(posedge clk);
        while (!frame_if.ready)
            @(posedge clk);
        want = track_frame(f);
        if (typed)
            want = typed_rec;
        pending.push_back(want);
        frames_sent++;
    endtask

    // result side: random back-pressure plus one long hold on request
    initial
    begin
        bit held;
        held = 1'b0;
        power_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request && !held)
            begin
                power_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                held = 1'b1;
                power_if.ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                power_if.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                power_if.ready <= 1'b1;
            end
            else
                power_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && power_if.valid && power_if.ready)
        begin
            got.level   = power_if.power_level;
            got.loaded  = power_if.power_valid;
            got.counted = power_if.frame_counted;
            results_seen++;
            if (got.counted)
                counted_seen++;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected transaction, power_level %h", $time, got.level);
                errors++;
            end
            else
            begin
                exp_rec = pending.pop_front();
                if (got.level !== exp_rec.level)
                begin
                    $display("%0t: power_level mismatch, expected %h, actual %h",
                             $time, exp_rec.level, got.level);
                    errors++;
                end
                if (got.loaded !== exp_rec.loaded)
                begin
                    $display("%0t: power_valid mismatch, expected %0b, actual %0b",
                             $time, exp_rec.loaded, got.loaded);
                    errors++;
                end
                if (got.counted !== exp_rec.counted)
                begin
                    $display("%0t: frame_counted mismatch, expected %0b, actual %0b",
                             $time, exp_rec.counted, got.counted);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        dir_row_t    row;
        frame_t      f;
        logic        en;
        logic        fmt;
        logic [7:0]  step;
        logic [3:0]  chans;
        logic [7:0]  mask;
        logic [7:0]  data;
        int          n_items;
        int          buf_left;
        int          wait_cnt;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = ewap_pkg::CFG_ENABLED;
        cfg_wdata = '0;
        frame_if.valid        = 1'b0;
        frame_if.buffer_start = 1'b0;
        frame_if.sample_0     = '0;
        frame_if.sample_1     = '0;
        frame_if.sample_2     = '0;
        frame_if.sample_3     = '0;
        frame_if.sample_4     = '0;
        frame_if.sample_5     = '0;
        frame_if.sample_6     = '0;
        frame_if.sample_7     = '0;
        idle_on      = 1'b1;
        hold_request = 1'b0;
        frames_sent  = 0;
        buf_left     = 0;

        cfg_en     = ewap_pkg::ENABLED_RST;
        cfg_fmt    = ewap_pkg::FORMAT_OK_RST;
        cfg_step   = ewap_pkg::STEP_RST;
        cfg_chans  = ewap_pkg::CHAN_RST;
        cfg_mask   = ewap_pkg::MASK_RST;
        phase_pos  = '0;
        pwr_acc    = '0;
        pwr_loaded = 1'b0;

        // disabled out of reset: nothing loads
        add_known(1'b1, {8{16'h8000}}, 31'h0, 1'b0, 1'b0);
        add_cfg(ewap_pkg::CFG_ENABLED, 8'h01);
        // full-scale stereo loads exactly one
        add_known(1'b1, {8{16'h8000}}, ewap_pkg::POWER_FULL, 1'b1, 1'b1);
        add_known(1'b0, {8{16'h8000}}, ewap_pkg::POWER_FULL, 1'b1, 1'b0);
        add_cfg(ewap_pkg::CFG_FORMAT_OK, 8'h00);
        add_known(1'b1, {8{16'h7FFF}}, ewap_pkg::POWER_FULL, 1'b1, 1'b0);
        add_cfg(ewap_pkg::CFG_FORMAT_OK, 8'h01);
        // step shrinks below the held phase
        add_cfg(ewap_pkg::CFG_DECIMATION_STEP, 8'd1);
        add_frame(1'b0, {8{16'h0000}});
        add_frame(1'b0, {8{16'h0000}});
        add_frame(1'b0, {8{16'h7FFF}});
        add_cfg(ewap_pkg::CFG_DECIMATION_STEP, 8'd0);
        add_frame(1'b0, {8{16'h8000}});
        add_frame(1'b0, {8{16'hFFFF}});
        add_cfg(ewap_pkg::CFG_CHANNEL_COUNT, 8'd0);
        add_frame(1'b0, {{7{16'h1234}}, 16'h8000});
        // upper data bits dropped, fifteen saturates to eight lanes
        add_cfg(ewap_pkg::CFG_CHANNEL_COUNT, 8'hFF);
        add_frame(1'b0, {8{16'h8000}});
        add_frame(1'b0, {4{16'h7FFF, 16'h8000}});
        add_cfg(ewap_pkg::CFG_CHANNEL_MASK, 8'h00);
        add_frame(1'b0, {8{16'h8000}});
        add_cfg(ewap_pkg::CFG_CHANNEL_COUNT, 8'd3);
        add_cfg(ewap_pkg::CFG_CHANNEL_MASK, 8'hF8);
        add_frame(1'b0, {8{16'h8000}});
        add_cfg(ewap_pkg::CFG_CHANNEL_MASK, 8'h05);
        add_frame(1'b0, {4{16'hAAAA, 16'h5555}});
        add_cfg(ewap_pkg::CFG_DECIMATION_STEP, 8'd192);
        add_frame(1'b1, {8{16'h7FFF}});
        add_frame(1'b0, {8{16'h8000}});
        add_frame(1'b0, {8{16'h8000}});
        add_cfg(ewap_pkg::CFG_DECIMATION_STEP, 8'd255);
        add_frame(1'b1, {8{16'h4000}});
        add_frame(1'b0, {8{16'h8000}});
        add_cfg(ewap_pkg::CFG_ENABLED, 8'hFE);
        add_frame(1'b1, {8{16'h8000}});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.is_cfg)
            begin
                drain_results(4);
                write_reg(row.idx, row.wdata);
            end
            else
                send_frame(row.frm, row.typed, row.want);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_results(4);
            en = 1'b1;
            fmt = 1'b1;
            mask = 8'hFF;
            case (p)
                0: begin step = 8'd1; chans = 4'd8; end
                1: begin step = 8'd255; chans = 4'd1; mask = 8'h01; end
                2: begin step = 8'd0; chans = 4'd0; mask = 8'($urandom); end
                3: begin step = 8'd2; chans = 4'd15; end
                6: begin en = 1'b0; step = 8'd1; chans = 4'd2; end
                9: begin fmt = 1'b0; step = 8'd1; chans = 4'd2; end
                default:
                begin
                    case ($urandom_range(0, 9))
                        0: step = 8'd0;
                        1: step = 8'($urandom_range(49, 255));
                        2, 3: step = 8'($urandom_range(7, 48));
                        default: step = 8'($urandom_range(1, 6));
                    endcase
                    chans = ($urandom_range(0, 3) == 0) ? 4'($urandom) :
                                                          4'($urandom_range(1, 8));
                    mask = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
                end
            endcase
            data = 8'($urandom);
            data[0] = en;
            write_reg(ewap_pkg::CFG_ENABLED, data);
            data = 8'($urandom);
            data[0] = fmt;
            write_reg(ewap_pkg::CFG_FORMAT_OK, data);
            write_reg(ewap_pkg::CFG_DECIMATION_STEP, step);
            data = 8'($urandom);
            data[3:0] = chans;
            write_reg(ewap_pkg::CFG_CHANNEL_COUNT, data);
            write_reg(ewap_pkg::CFG_CHANNEL_MASK, mask);

            idle_on = (p < NUM_PHASES - 2);
            n_items = (!en || !fmt) ? GATED_ITEMS : ITEMS_PER_PHASE;
            // stall the result side long enough to back the block up
            if (p == 5)
                hold_request = 1'b1;

            for (int i = 0; i < n_items; i++)
            begin
                if (p == 7 && i == n_items / 2)
                    drain_results(0);
                if (buf_left == 0)
                begin
                    f.buf_start = 1'b1;
                    buf_left = ($urandom_range(0, 15) == 0) ? $urandom_range(64, 480) :
                                                              $urandom_range(0, 40);
                end
                else
                begin
                    f.buf_start = 1'b0;
                    buf_left--;
                end
                // stray or missing buffer marks
                if ($urandom_range(0, 49) == 0)
                    f.buf_start = ~f.buf_start;
                for (int c = 0; c < ewap_pkg::NUM_SAMPLES; c++)
                    f.smp[c] = pick_sample();
                send_frame(f, 1'b0, '0);
            end
        end

        frame_if.valid <= 1'b0;
        wait_cnt = 0;
        while (pending.size() != 0 && wait_cnt < 5000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (30) @(posedge clk);
        if (pending.size() != 0)
            $display("%0t: %0d expected results never arrived", $time, pending.size());

        $display("Sent %0d frames over %0d register settings; %0d results checked, %0d updates",
                 frames_sent, NUM_PHASES + 1, results_seen, counted_seen);
        $display("Covered gating, step wrap and clamping, lane masking and a %0d-cycle stall",
                 LONG_HOLD);
        if (errors == 0 && pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
